// ----- hw/rtl/crcfp_pkg.sv -----
// shared types and constants of the crc16 frame parser
package crcfp_pkg;

	// default payload buffer depth
	localparam int MAX_PAYLOAD_DEF = 64;

	// fixed field widths
	localparam int BYTE_W  = 8;
	localparam int LEN_W   = 7;
	localparam int INDEX_W = 6;
	localparam int CNT_W   = 32;
	localparam int STAT_W  = 3;

	// configuration register indexes
	localparam logic [1:0] REG_MAGIC_FIRST  = 2'd0;
	localparam logic [1:0] REG_MAGIC_SECOND = 2'd1;
	localparam logic [1:0] REG_VERSION      = 2'd2;
	localparam logic [1:0] REG_MAX_LENGTH   = 2'd3;

	// result status codes
	localparam logic [STAT_W-1:0] STATUS_FRAME   = 3'd0;
	localparam logic [STAT_W-1:0] STATUS_SYNC    = 3'd1;
	localparam logic [STAT_W-1:0] STATUS_VERSION = 3'd2;
	localparam logic [STAT_W-1:0] STATUS_LENGTH  = 3'd3;
	localparam logic [STAT_W-1:0] STATUS_CRC     = 3'd4;

	// queue depth between parser and release side
	localparam int QUEUE_DEPTH = 2;

	// one parser event: a status or an accepted frame header
	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [BYTE_W-1:0] frame_type;
		logic [15:0]       sequence_number;
		logic [LEN_W-1:0]  payload_length;
		logic [CNT_W-1:0]  valid_count;
		logic [CNT_W-1:0]  crc_error_count;
		logic [CNT_W-1:0]  format_error_count;
		logic [CNT_W-1:0]  resync_count;
	} crcfp_event_t;

	// payload buffer write from the parser
	typedef struct packed {
		logic               we;
		logic [INDEX_W-1:0] addr;
		logic [BYTE_W-1:0]  data;
	} crcfp_wr_t;

endpackage

// ----- hw/rtl/crcfp_front.sv -----
// byte parser: sync hunt, header fields, crc check, payload buffer writes
module crcfp_front #(
	parameter int MAX_PAYLOAD = crcfp_pkg::MAX_PAYLOAD_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [7:0]                       s_tdata,
	input  logic                             cfg_we,
	input  logic [1:0]                       cfg_addr,
	input  logic [7:0]                       cfg_wdata,
	input  logic                             q_full,
	input  logic                             release_done,
	output logic                             ev_push,
	output crcfp_pkg::crcfp_event_t          ev,
	output crcfp_pkg::crcfp_wr_t             wr
);

	localparam logic [3:0] PH_MAGIC0  = 4'd0;
	localparam logic [3:0] PH_MAGIC1  = 4'd1;
	localparam logic [3:0] PH_VERSION = 4'd2;
	localparam logic [3:0] PH_TYPE    = 4'd3;
	localparam logic [3:0] PH_SEQ0    = 4'd4;
	localparam logic [3:0] PH_SEQ1    = 4'd5;
	localparam logic [3:0] PH_LENGTH  = 4'd6;
	localparam logic [3:0] PH_PAYLOAD = 4'd7;
	localparam logic [3:0] PH_CRC0    = 4'd8;
	localparam logic [3:0] PH_CRC1    = 4'd9;

	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [6:0]  MAX_LEN  = 7'(MAX_PAYLOAD);

	// one byte of crc-16/ccitt, msb first
	function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] r;
		int k;
		r = c ^ {b, 8'h00};
		for (k = 0; k < 8; k++) begin
			r = r[15] ? ({r[14:0], 1'b0} ^ CRC_POLY) : {r[14:0], 1'b0};
		end
		return r;
	endfunction

	logic [7:0]  magic_first_q, magic_second_q, version_q;
	logic [6:0]  max_length_q;
	logic [3:0]  phase_q, phase_d;
	logic [7:0]  type_q, type_d;
	logic [15:0] seq_q, seq_d;
	logic [6:0]  len_q, len_d;
	logic [6:0]  fill_q, fill_d;
	logic [15:0] crc_q, crc_d;
	logic [7:0]  crc_lo_q, crc_lo_d;
	logic [31:0] ok_q, ok_d, crcerr_q, crcerr_d, fmt_q, fmt_d, resync_q, resync_d;
	logic        busy_q, busy_d;
	logic        accept, do_clear;
	logic [6:0]  lim;
	logic [6:0]  fill_inc;

	// payload phase waits while the previous frame is still being released
	assign s_tready = !q_full && !(phase_q == PH_PAYLOAD && busy_q);
	assign accept   = s_tvalid && s_tready;
	assign lim      = (max_length_q > MAX_LEN) ? MAX_LEN : max_length_q;
	assign fill_inc = fill_q + 7'd1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_first_q  <= 8'hAA;
			magic_second_q <= 8'h55;
			version_q      <= 8'h01;
			max_length_q   <= 7'd64;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				crcfp_pkg::REG_MAGIC_FIRST:  magic_first_q  <= cfg_wdata;
				crcfp_pkg::REG_MAGIC_SECOND: magic_second_q <= cfg_wdata;
				crcfp_pkg::REG_VERSION:      version_q      <= cfg_wdata;
				crcfp_pkg::REG_MAX_LENGTH:   max_length_q   <= cfg_wdata[6:0];
				default: ;
			endcase
		end
	end

	// parse step for one accepted byte
	always_comb begin
		phase_d  = phase_q;
		type_d   = type_q;
		seq_d    = seq_q;
		len_d    = len_q;
		fill_d   = fill_q;
		crc_d    = crc_q;
		crc_lo_d = crc_lo_q;
		ok_d     = ok_q;
		crcerr_d = crcerr_q;
		fmt_d    = fmt_q;
		resync_d = resync_q;
		do_clear = 1'b0;
		ev_push  = 1'b0;
		ev       = '0;
		wr       = '0;
		if (accept) begin
			unique case (phase_q)
				PH_MAGIC0: begin
					if (s_tdata == magic_first_q) phase_d = PH_MAGIC1;
				end
				PH_MAGIC1: begin
					if (s_tdata == magic_second_q) begin
						phase_d = PH_VERSION;
					end else if (s_tdata != magic_first_q) begin
						phase_d   = PH_MAGIC0;
						resync_d  = resync_q + 32'd1;
						ev_push   = 1'b1;
						ev.status = crcfp_pkg::STATUS_SYNC;
					end
				end
				PH_VERSION: begin
					if (s_tdata != version_q) begin
						fmt_d     = fmt_q + 32'd1;
						resync_d  = resync_q + 32'd1;
						do_clear  = 1'b1;
						ev_push   = 1'b1;
						ev.status = crcfp_pkg::STATUS_VERSION;
					end else begin
						crc_d   = crc_byte(CRC_INIT, s_tdata);
						phase_d = PH_TYPE;
					end
				end
				PH_TYPE: begin
					type_d  = s_tdata;
					crc_d   = crc_byte(crc_q, s_tdata);
					phase_d = PH_SEQ0;
				end
				PH_SEQ0: begin
					seq_d   = {8'h00, s_tdata};
					crc_d   = crc_byte(crc_q, s_tdata);
					phase_d = PH_SEQ1;
				end
				PH_SEQ1: begin
					seq_d   = {s_tdata, seq_q[7:0]};
					crc_d   = crc_byte(crc_q, s_tdata);
					phase_d = PH_LENGTH;
				end
				PH_LENGTH: begin
					if (s_tdata > {1'b0, lim}) begin
						fmt_d     = fmt_q + 32'd1;
						resync_d  = resync_q + 32'd1;
						do_clear  = 1'b1;
						ev_push   = 1'b1;
						ev.status = crcfp_pkg::STATUS_LENGTH;
					end else begin
						len_d   = s_tdata[6:0];
						fill_d  = 7'd0;
						crc_d   = crc_byte(crc_q, s_tdata);
						phase_d = (s_tdata == 8'd0) ? PH_CRC0 : PH_PAYLOAD;
					end
				end
				PH_PAYLOAD: begin
					wr.we   = (fill_q < MAX_LEN);
					wr.addr = fill_q[5:0];
					wr.data = s_tdata;
					fill_d  = fill_inc;
					crc_d   = crc_byte(crc_q, s_tdata);
					if (fill_inc >= len_q) phase_d = PH_CRC0;
				end
				PH_CRC0: begin
					crc_lo_d = s_tdata;
					phase_d  = PH_CRC1;
				end
				PH_CRC1: begin
					ev_push  = 1'b1;
					do_clear = 1'b1;
					if ({s_tdata, crc_lo_q} != crc_q) begin
						crcerr_d  = crcerr_q + 32'd1;
						resync_d  = resync_q + 32'd1;
						ev.status = crcfp_pkg::STATUS_CRC;
					end else begin
						ok_d               = ok_q + 32'd1;
						ev.status          = crcfp_pkg::STATUS_FRAME;
						ev.frame_type      = type_q;
						ev.sequence_number = seq_q;
						ev.payload_length  = (len_q > MAX_LEN) ? 7'd0 : len_q;
					end
				end
				default: begin
					do_clear = 1'b1;
				end
			endcase
			// return to hunting; after an error, re-armed if the byte is the first magic
			if (do_clear) begin
				type_d   = 8'd0;
				seq_d    = 16'd0;
				len_d    = 7'd0;
				fill_d   = 7'd0;
				crc_d    = CRC_INIT;
				crc_lo_d = 8'd0;
				phase_d  = (ev_push && ev.status != crcfp_pkg::STATUS_FRAME
					&& s_tdata == magic_first_q) ? PH_MAGIC1 : PH_MAGIC0;
			end
		end
		ev.valid_count        = ok_d;
		ev.crc_error_count    = crcerr_d;
		ev.format_error_count = fmt_d;
		ev.resync_count       = resync_d;
	end

	// payload buffer ownership: held from frame accept until its last byte leaves
	always_comb begin
		busy_d = busy_q;
		if (release_done) busy_d = 1'b0;
		if (ev_push && ev.status == crcfp_pkg::STATUS_FRAME && ev.payload_length != 7'd0)
			busy_d = 1'b1;
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_MAGIC0;
			type_q   <= 8'd0;
			seq_q    <= 16'd0;
			len_q    <= 7'd0;
			fill_q   <= 7'd0;
			crc_q    <= CRC_INIT;
			crc_lo_q <= 8'd0;
			ok_q     <= 32'd0;
			crcerr_q <= 32'd0;
			fmt_q    <= 32'd0;
			resync_q <= 32'd0;
			busy_q   <= 1'b0;
		end else begin
			phase_q  <= phase_d;
			type_q   <= type_d;
			seq_q    <= seq_d;
			len_q    <= len_d;
			fill_q   <= fill_d;
			crc_q    <= crc_d;
			crc_lo_q <= crc_lo_d;
			ok_q     <= ok_d;
			crcerr_q <= crcerr_d;
			fmt_q    <= fmt_d;
			resync_q <= resync_d;
			busy_q   <= busy_d;
		end
	end

endmodule

// ----- hw/rtl/crcfp_queue.sv -----
// short event queue between parser and release side
module crcfp_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  crcfp_pkg::crcfp_event_t push_data,
	input  logic                    pop,
	output crcfp_pkg::crcfp_event_t pop_data,
	output logic                    full,
	output logic                    empty
);

	localparam int PTR_W = (crcfp_pkg::QUEUE_DEPTH > 1) ? $clog2(crcfp_pkg::QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(crcfp_pkg::QUEUE_DEPTH + 1);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(crcfp_pkg::QUEUE_DEPTH);
	localparam logic [PTR_W-1:0] LAST_C  = PTR_W'(crcfp_pkg::QUEUE_DEPTH - 1);

	crcfp_pkg::crcfp_event_t entry_q [crcfp_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full     = (count_q == DEPTH_C);
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = entry_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) entry_q[wr_ptr_q] <= push_data;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= (wr_ptr_q == LAST_C) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= (rd_ptr_q == LAST_C) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)      count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

endmodule

// ----- hw/rtl/crcfp_back.sv -----
// release side: payload buffer and result output register
module crcfp_back #(
	parameter int MAX_PAYLOAD = crcfp_pkg::MAX_PAYLOAD_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  crcfp_pkg::crcfp_wr_t    wr,
	input  logic                    q_empty,
	input  crcfp_pkg::crcfp_event_t q_data,
	output logic                    q_pop,
	output logic                    release_done,
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output logic [175:0]            m_tdata, // frame_type, sequence_number, payload_length,
	                                         // byte_index, payload_byte, valid_count,
	                                         // crc_error_count, format_error_count,
	                                         // resync_count, zero fill
	output logic [3:0]              m_tuser, // status, has_byte
	output logic                    m_tlast
);

	localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

	localparam logic [1:0] B_IDLE = 2'd0;
	localparam logic [1:0] B_READ = 2'd1;
	localparam logic [1:0] B_SHOW = 2'd2;

	logic [7:0]              mem [MAX_PAYLOAD];
	logic [7:0]              rd_q;
	logic [1:0]              st_q;
	crcfp_pkg::crcfp_event_t ev_q;
	logic [5:0]              idx_q;
	logic                    has_q;
	logic                    last;
	logic [7:0]              pbyte;

	// payload buffer, written by the parser
	always_ff @(posedge clk) begin
		if (wr.we) mem[wr.addr[ADDR_W-1:0]] <= wr.data;
	end

	// registered read of the current byte
	always_ff @(posedge clk) begin
		rd_q <= mem[idx_q[ADDR_W-1:0]];
	end

	assign last  = !has_q || ({1'b0, idx_q} + 7'd1 == ev_q.payload_length);
	assign pbyte = has_q ? rd_q : 8'd0;
	assign q_pop = (st_q == B_IDLE) && !q_empty;
	assign m_tvalid     = (st_q == B_SHOW);
	assign release_done = m_tvalid && m_tready && has_q && last;

	// release sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= B_IDLE;
			idx_q <= 6'd0;
			has_q <= 1'b0;
		end else begin
			unique case (st_q)
				B_IDLE: begin
					if (!q_empty) begin
						idx_q <= 6'd0;
						if (q_data.status == crcfp_pkg::STATUS_FRAME
							&& q_data.payload_length != 7'd0) begin
							has_q <= 1'b1;
							st_q  <= B_READ;
						end else begin
							has_q <= 1'b0;
							st_q  <= B_SHOW;
						end
					end
				end
				B_READ: begin
					st_q <= B_SHOW;
				end
				B_SHOW: begin
					if (m_tready) begin
						if (last) begin
							st_q <= B_IDLE;
						end else begin
							idx_q <= idx_q + 6'd1;
							st_q  <= B_READ;
						end
					end
				end
				default: begin
					st_q <= B_IDLE;
				end
			endcase
		end
	end

	// event held for the whole run
	always_ff @(posedge clk) begin
		if (q_pop) ev_q <= q_data;
	end

	// result packing
	assign m_tdata = {3'b000, ev_q.resync_count, ev_q.format_error_count,
		ev_q.crc_error_count, ev_q.valid_count, pbyte, idx_q,
		ev_q.payload_length, ev_q.sequence_number, ev_q.frame_type};
	assign m_tuser = {has_q, ev_q.status};
	assign m_tlast = last;

endmodule

// ----- hw/rtl/crc16_frame_parser_top.sv -----
// top level of the crc16 frame parser
//
// channel   handshake                  payload
// s_*       s_tvalid / s_tready        s_tdata: data_byte
// m_*       m_tvalid / m_tready        m_tdata: header, byte, counters; m_tuser: status,
//                                      has_byte; m_tlast: last
// cfg_*     cfg_we                     cfg_addr: register index, cfg_wdata: value
//
// the parser takes one byte per cycle while s_tready is high; crc and header checks finish in the same cycle
// a released result passes the payload buffer read when it has a byte, then the output register
// a frame's payload bytes wait while the previous frame's payload is still released
// input also waits while the two-entry event queue is full
// reset clears the parser, counters and queue at once; no clearing pass
module crc16_frame_parser_top #(
	parameter int MAX_PAYLOAD = crcfp_pkg::MAX_PAYLOAD_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,  // data_byte
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [175:0] m_tdata,  // frame_type, sequence_number, payload_length, byte_index,
	                               // payload_byte, valid_count, crc_error_count,
	                               // format_error_count, resync_count, zero fill
	output logic [3:0]   m_tuser,  // status, has_byte
	output logic         m_tlast,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_addr,
	input  logic [7:0]   cfg_wdata
);

	crcfp_pkg::crcfp_event_t ev, q_data;
	crcfp_pkg::crcfp_wr_t    wr;
	logic ev_push, q_full, q_empty, q_pop, release_done;

	crcfp_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.cfg_we       (cfg_we),
		.cfg_addr     (cfg_addr),
		.cfg_wdata    (cfg_wdata),
		.q_full       (q_full),
		.release_done (release_done),
		.ev_push      (ev_push),
		.ev           (ev),
		.wr           (wr)
	);

	crcfp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (ev_push),
		.push_data (ev),
		.pop       (q_pop),
		.pop_data  (q_data),
		.full      (q_full),
		.empty     (q_empty)
	);

	crcfp_back #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr           (wr),
		.q_empty      (q_empty),
		.q_data       (q_data),
		.q_pop        (q_pop),
		.release_done (release_done),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser),
		.m_tlast      (m_tlast)
	);

endmodule
